### hdl/bftp_pkg.sv
// shared types, constants and arctangent table for the bearing pipeline
package bftp_pkg;

    // parameter defaults
    localparam int COORD_BITS_DEF      = 32;
    localparam int ANGLE_FRAC_BITS_DEF = 16;
    localparam int ATAN_STAGES_DEF     = 24;

    // fixed formats
    localparam int ATAN_TAB_LEN = 32;
    localparam int ACC_FRAC     = 32;
    localparam int CORDIC_W     = 64;
    localparam int ZW           = 41;
    localparam int THR_W        = 20;
    localparam logic [THR_W-1:0] THR_RESET = 20'd1;

    // beat field widths
    localparam int EAST_W     = 29;
    localparam int NORTH_W    = 28;
    localparam int IN_DATA_W  = 120;
    localparam int BEARING_W  = 25;
    localparam int OUT_DATA_W = 32;

    // direction class decided before the arctangent
    typedef enum logic [1:0] {
        DIR_GENERAL    = 2'd0,
        DIR_NORTH_ZERO = 2'd1,
        DIR_EAST_ZERO  = 2'd2
    } dir_kind_t;

    // sideband carried alongside each item
    typedef struct packed {
        dir_kind_t kind;
        logic      de_neg;
        logic      dn_pos;
    } side_t;

    // atan(2^-i) in degrees, 32 fractional bits, rounded to nearest
    localparam logic signed [ZW-1:0] ATAN_TAB [ATAN_TAB_LEN] = '{
        41'sd193273528320, 41'sd114096026022, 41'sd60285206653, 41'sd30601712202,
        41'sd15360239180,  41'sd7687607525,   41'sd3844741810,  41'sd1922488225,
        41'sd961258780,    41'sd480631223,    41'sd240315841,   41'sd120157949,
        41'sd60078978,     41'sd30039490,     41'sd15019745,    41'sd7509872,
        41'sd3754936,      41'sd1877468,      41'sd938734,      41'sd469367,
        41'sd234684,       41'sd117342,       41'sd58671,       41'sd29335,
        41'sd14668,        41'sd7334,         41'sd3667,        41'sd1833,
        41'sd917,          41'sd458,          41'sd229,         41'sd115
    };

endpackage

### hdl/bearing_from_two_points_unit.sv
// compass bearing between two points: difference, cordic arctangent, quadrant
//
// Takes one point pair per beat and returns one bearing per beat, clockwise
// from north in degrees with ANGLE_FRAC_BITS fractional bits. The block is a
// pipeline of ATAN_STAGES + 4 register stages (28 at the defaults, at most
// 36): coordinate differences, magnitude and axis tests, one vectoring
// cordic rotation per stage, clamp and rounding, quadrant placement into the
// output register. A new pair is taken every cycle while s_tready is high.
// When m_tready is low only the stages that hold an item stop, so empty
// stages keep filling and s_tready stays high until every stage is occupied.
// The zero threshold should be written only while no beat is in flight.
module bearing_from_two_points_unit #(
    parameter int COORD_BITS      = bftp_pkg::COORD_BITS_DEF,
    parameter int ANGLE_FRAC_BITS = bftp_pkg::ANGLE_FRAC_BITS_DEF,
    parameter int ATAN_STAGES     = bftp_pkg::ATAN_STAGES_DEF
) (
    input  logic                               aclk,
    input  logic                               aresetn,
    // configuration: zero_threshold
    input  logic                               cfg_we,
    input  logic [bftp_pkg::THR_W-1:0]         cfg_wdata,
    // input beats
    input  logic                               s_tvalid,
    output logic                               s_tready,
    // start_east[28:0], start_north[56:29], end_east[85:57], end_north[113:86]
    input  logic [bftp_pkg::IN_DATA_W-1:0]     s_tdata,
    // result beats
    output logic                               m_tvalid,
    input  logic                               m_tready,
    // bearing[24:0]
    output logic [bftp_pkg::OUT_DATA_W-1:0]    m_tdata
);

    localparam int CB     = COORD_BITS;
    localparam int AFB    = ANGLE_FRAC_BITS;
    localparam int NS     = (ATAN_STAGES > bftp_pkg::ATAN_TAB_LEN) ?
                            bftp_pkg::ATAN_TAB_LEN : ATAN_STAGES;
    localparam int NP     = NS + 4;
    localparam int CW     = bftp_pkg::CORDIC_W;
    localparam int ZW     = bftp_pkg::ZW;
    localparam int DIFF_W = 31;
    localparam int DW     = ((CB > DIFF_W) ? CB : DIFF_W) + 1;
    localparam int TW     = CB + bftp_pkg::THR_W;
    localparam int PRE_SH = 61 - CB;
    localparam int RSH    = bftp_pkg::ACC_FRAC - AFB;
    localparam int AW     = AFB + 7;
    localparam int RW     = AFB + 10;
    localparam int BW     = bftp_pkg::BEARING_W;

    localparam logic [DW-1:0]        SAT_HI_U = (DW'(1) << (CB - 1)) - DW'(1);
    localparam logic signed [DW-1:0] SAT_HI   = signed'(SAT_HI_U);
    localparam logic signed [DW-1:0] SAT_LO   = ~SAT_HI;
    localparam logic signed [ZW-1:0] Z_TOP    = ZW'(90) << bftp_pkg::ACC_FRAC;
    localparam logic [ZW-1:0]        Z_HALF   = ZW'(1) << (RSH - 1);
    localparam logic [AW-1:0]        A_MAX    = AW'(90) << AFB;
    localparam logic [RW-1:0]        Q90      = RW'(90) << AFB;
    localparam logic [RW-1:0]        Q180     = RW'(180) << AFB;
    localparam logic [RW-1:0]        Q270     = RW'(270) << AFB;
    localparam logic [RW-1:0]        Q360     = RW'(360) << AFB;

    // control and storage
    logic [bftp_pkg::THR_W-1:0] thr_reg;
    logic [NP-1:0]              v_reg;
    logic [NP-1:0]              en;

    logic signed [CB-1:0]    de_reg, dn_reg;
    logic signed [CB-1:0]    de_next, dn_next;
    logic signed [CW-1:0]    cx0_next, cy0_next;
    bftp_pkg::side_t         sb0_next;
    logic signed [CW-1:0]    cx_reg [NS+1];
    logic signed [CW-1:0]    cy_reg [NS+1];
    logic signed [ZW-1:0]    cz_reg [NS+1];
    logic signed [CW-1:0]    cx_next [NS+1];
    logic signed [CW-1:0]    cy_next [NS+1];
    logic signed [ZW-1:0]    cz_next [NS+1];
    bftp_pkg::side_t         sb_reg [NS+2];
    bftp_pkg::side_t         sb_next [NS+2];
    logic [AW-1:0]           a_reg, a_next;
    logic [BW-1:0]           bear_reg, bear_next;

    // stage enables: a stage moves when m_tready is high or any stage from it to the output is free
    for (genvar p = 0; p < NP; p++) begin : g_en
        assign en[p] = m_tready | ~(&v_reg[NP-1:p]);
    end

    assign s_tready = en[0];
    assign m_tvalid = v_reg[NP-1];
    assign m_tdata  = {{(bftp_pkg::OUT_DATA_W - BW){1'b0}}, bear_reg};

    // threshold register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            thr_reg <= bftp_pkg::THR_RESET;
        end else if (cfg_we) begin
            thr_reg <= cfg_wdata;
        end
    end

    // differences with saturation to the coordinate width
    always_comb begin
        logic signed [DIFF_W-1:0] de_full, dn_full;
        logic signed [DW-1:0]     de_ext, dn_ext;
        de_full = {{2{s_tdata[85]}}, s_tdata[85:57]} - {{2{s_tdata[28]}}, s_tdata[28:0]};
        dn_full = {{3{s_tdata[113]}}, s_tdata[113:86]} - {{3{s_tdata[56]}}, s_tdata[56:29]};
        de_ext  = {{(DW - DIFF_W){de_full[DIFF_W-1]}}, de_full};
        dn_ext  = {{(DW - DIFF_W){dn_full[DIFF_W-1]}}, dn_full};
        if (de_ext > SAT_HI) begin
            de_ext = SAT_HI;
        end else if (de_ext < SAT_LO) begin
            de_ext = SAT_LO;
        end
        if (dn_ext > SAT_HI) begin
            dn_ext = SAT_HI;
        end else if (dn_ext < SAT_LO) begin
            dn_ext = SAT_LO;
        end
        de_next = de_ext[CB-1:0];
        dn_next = dn_ext[CB-1:0];
    end

    // magnitudes, axis tests and cordic start vector
    always_comb begin
        logic [CB-1:0] ae, an;
        logic          north_zero, east_zero;
        ae = de_reg[CB-1] ? CB'(~de_reg + 1'b1) : CB'(de_reg);
        an = dn_reg[CB-1] ? CB'(~dn_reg + 1'b1) : CB'(dn_reg);
        north_zero = (TW'(an) < TW'(thr_reg)) || (an == '0);
        east_zero  = (TW'(ae) < TW'(thr_reg)) || (ae == '0);
        if (north_zero) begin
            sb0_next.kind = bftp_pkg::DIR_NORTH_ZERO;
        end else if (east_zero) begin
            sb0_next.kind = bftp_pkg::DIR_EAST_ZERO;
        end else begin
            sb0_next.kind = bftp_pkg::DIR_GENERAL;
        end
        sb0_next.de_neg = de_reg[CB-1];
        sb0_next.dn_pos = !dn_reg[CB-1] && (dn_reg != '0);
        cx0_next = signed'(CW'(ae) << PRE_SH);
        cy0_next = signed'(CW'(an) << PRE_SH);
    end

    // one vectoring rotation per stage
    always_comb begin
        cx_next[0] = cx0_next;
        cy_next[0] = cy0_next;
        cz_next[0] = '0;
        sb_next[0] = sb0_next;
        for (int k = 0; k < NS; k++) begin
            if (!cy_reg[k][CW-1]) begin
                cx_next[k+1] = cx_reg[k] + (cy_reg[k] >>> k);
                cy_next[k+1] = cy_reg[k] - (cx_reg[k] >>> k);
                cz_next[k+1] = cz_reg[k] + bftp_pkg::ATAN_TAB[k];
            end else begin
                cx_next[k+1] = cx_reg[k] - (cy_reg[k] >>> k);
                cy_next[k+1] = cy_reg[k] + (cx_reg[k] >>> k);
                cz_next[k+1] = cz_reg[k] - bftp_pkg::ATAN_TAB[k];
            end
            sb_next[k+1] = sb_reg[k];
        end
        sb_next[NS+1] = sb_reg[NS];
    end

    // clamp to [0, 90] degrees and round to the output fraction
    always_comb begin
        logic signed [ZW-1:0] zc;
        logic [ZW-1:0]        zr;
        zc = cz_reg[NS];
        if (zc < 0) begin
            zc = '0;
        end else if (zc > Z_TOP) begin
            zc = Z_TOP;
        end
        zr     = unsigned'(zc) + Z_HALF;
        a_next = zr[RSH +: AW];
    end

    // quadrant placement and axis directions
    always_comb begin
        logic [RW-1:0]      a_ext, r;
        logic [RW+BW-1:0]   r_wide;
        bftp_pkg::side_t    sb;
        sb    = sb_reg[NS+1];
        a_ext = RW'(a_reg);
        case (sb.kind)
            bftp_pkg::DIR_NORTH_ZERO: begin
                r = sb.de_neg ? Q270 : Q90;
            end
            bftp_pkg::DIR_EAST_ZERO: begin
                r = sb.dn_pos ? '0 : Q180;
            end
            bftp_pkg::DIR_GENERAL: begin
                if (sb.dn_pos) begin
                    r = sb.de_neg ? (Q270 + a_ext) : (Q90 - a_ext);
                end else begin
                    r = sb.de_neg ? (Q270 - a_ext) : (Q90 + a_ext);
                end
            end
            default: begin
                r = '0;
            end
        endcase
        // a full turn wraps to north
        if (r >= Q360) begin
            r = r - Q360;
        end
        r_wide    = {{BW{1'b0}}, r};
        bear_next = r_wide[BW-1:0];
    end

    // valid bits
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v_reg <= '0;
        end else begin
            if (en[0]) begin
                v_reg[0] <= s_tvalid;
            end
            for (int p = 1; p < NP; p++) begin
                if (en[p]) begin
                    v_reg[p] <= v_reg[p-1];
                end
            end
        end
    end

    // payload registers
    always_ff @(posedge aclk) begin
        if (en[0]) begin
            de_reg <= de_next;
            dn_reg <= dn_next;
        end
        for (int k = 0; k <= NS; k++) begin
            if (en[k+1]) begin
                cx_reg[k] <= cx_next[k];
                cy_reg[k] <= cy_next[k];
                cz_reg[k] <= cz_next[k];
                sb_reg[k] <= sb_next[k];
            end
        end
        if (en[NS+2]) begin
            sb_reg[NS+1] <= sb_next[NS+1];
            a_reg        <= a_next;
        end
        if (en[NS+3]) begin
            bear_reg <= bear_next;
        end
    end

    // an empty output register never blocks the input side
    assert property (@(posedge aclk) disable iff (!aresetn)
        !m_tvalid |-> s_tready)
        else $error("input stalled while output register empty");

    // a result appears only after the rounding stage held an item
    assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_tvalid) |-> $past(v_reg[NP-2]))
        else $error("result appeared without a preceding item");

    // the rounded arctangent stays within a quarter turn
    assert property (@(posedge aclk) disable iff (!aresetn)
        v_reg[NP-2] |-> (a_reg <= A_MAX))
        else $error("arctangent above 90 degrees");

endmodule

### tb/testbench.sv
// self-checking testbench for the two-point compass bearing pipeline
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int COORD_BITS      = bftp_pkg::COORD_BITS_DEF;
    localparam int ANGLE_FRAC_BITS = bftp_pkg::ANGLE_FRAC_BITS_DEF;
    localparam int ATAN_STAGES     = bftp_pkg::ATAN_STAGES_DEF;
    localparam int PIPE_LAT        = ATAN_STAGES + 4;
    localparam int HOLD_CYCLES     = 200;
    localparam int CYCLE_LIMIT     = 200000;
    localparam int MAX_REPORTS     = 10;
    localparam int BEARING_W       = bftp_pkg::BEARING_W;
    localparam int EAST_W          = bftp_pkg::EAST_W;
    localparam int NORTH_W         = bftp_pkg::NORTH_W;
    localparam int IN_DATA_W       = bftp_pkg::IN_DATA_W;
    localparam int OUT_DATA_W      = bftp_pkg::OUT_DATA_W;
    localparam int THR_W           = bftp_pkg::THR_W;
    localparam int ACC_FRAC        = bftp_pkg::ACC_FRAC;

    // compass points in output units
    localparam logic [BEARING_W-1:0] BRG_NORTH = '0;
    localparam logic [BEARING_W-1:0] BRG_EAST  = 25'd5898240;
    localparam logic [BEARING_W-1:0] BRG_SOUTH = 25'd11796480;
    localparam logic [BEARING_W-1:0] BRG_WEST  = 25'd17694720;

    typedef struct packed {
        logic signed [EAST_W-1:0]  start_east;
        logic signed [NORTH_W-1:0] start_north;
        logic signed [EAST_W-1:0]  end_east;
        logic signed [NORTH_W-1:0] end_north;
        logic                      known;
        logic [BEARING_W-1:0]      want;
    } pair_row_t;

    typedef struct {
        logic [IN_DATA_W-1:0]  pair;
        logic [OUT_DATA_W-1:0] word;
    } bearing_exp_t;

    // directed pairs; known rows carry a bearing read straight off the axis rules
    localparam int N_DIRECTED = 22;
    localparam pair_row_t DIRECTED_ROWS [N_DIRECTED] = '{
        '{0, 0, 0, 0, 1'b1, BRG_EAST},
        '{0, 0, -5, 0, 1'b1, BRG_WEST},
        '{0, 0, 5, 0, 1'b1, BRG_EAST},
        '{0, 0, 0, 7, 1'b1, BRG_NORTH},
        '{0, 0, 0, -7, 1'b1, BRG_SOUTH},
        '{0, 0, 100, 100, 1'b0, '0},
        '{0, 0, -100, 100, 1'b0, '0},
        '{0, 0, 100, -100, 1'b0, '0},
        '{0, 0, -100, -100, 1'b0, '0},
        '{-180000000, -90000000, 180000000, 90000000, 1'b0, '0},
        '{180000000, 90000000, -180000000, -90000000, 1'b0, '0},
        '{1, -90000000, 0, 90000000, 1'b0, '0},
        '{0, -90000000, 1, 90000000, 1'b0, '0},
        '{-180000000, 0, 180000000, 1, 1'b0, '0},
        '{180000000, 0, -180000000, -1, 1'b0, '0},
        '{268435455, -134217728, -268435456, 134217727, 1'b0, '0},
        '{-268435456, 134217727, 268435455, -134217728, 1'b0, '0},
        '{-1, -1, -1, -1, 1'b1, BRG_EAST},
        '{12345, -6789, 12345, -6789, 1'b1, BRG_EAST},
        '{7, -2, 4, 2, 1'b0, '0},
        '{-180000000, 90000000, -180000000, -90000000, 1'b1, BRG_SOUTH},
        '{180000000, -90000000, -180000000, -90000000, 1'b1, BRG_WEST}
    };

    logic                   aclk      = 1'b0;
    logic                   aresetn   = 1'b0;
    logic                   cfg_we    = 1'b0;
    logic [THR_W-1:0]       cfg_wdata = '0;
    logic                   s_tvalid  = 1'b0;
    logic                   s_tready;
    // start_east[28:0], start_north[56:29], end_east[85:57], end_north[113:86]
    logic [IN_DATA_W-1:0]   s_tdata   = '0;
    logic                   m_tvalid;
    logic                   m_tready  = 1'b0;
    // bearing[24:0]
    logic [OUT_DATA_W-1:0]  m_tdata;

    logic [THR_W-1:0] zero_thr = bftp_pkg::THR_RESET;
    pair_row_t        row_answer_q [$];
    bearing_exp_t     bearing_q [$];
    int               src_idle_pct   = 0;
    int               sink_stall_pct = 0;
    bit               hold_ask   = 1'b0;
    bit               hold_taken = 1'b0;
    int               hold_left  = 0;
    int               mismatches = 0;
    int               n_checked  = 0;
    int               n_pairs    = 0;
    int               n_nzero    = 0;
    int               n_ezero    = 0;
    int               n_general  = 0;
    int               cycles     = 0;

    bearing_from_two_points_unit dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

    always #2 aclk = ~aclk;

    // clip a coordinate difference to the signed coordinate width
    function automatic longint clip_diff(input longint d);
        longint hi;
        longint lo;
        hi = (64'sd1 <<< (COORD_BITS - 1)) - 1;
        lo = -hi - 1;
        if (d > hi) return hi;
        if (d < lo) return lo;
        return d;
    endfunction

    // bearing of one point pair under a given zero threshold
    function automatic logic [BEARING_W-1:0] predict_bearing(
        input  logic [IN_DATA_W-1:0] pair,
        input  logic [THR_W-1:0]     thr,
        output bftp_pkg::dir_kind_t  kind
    );
        logic signed [EAST_W-1:0]  se;
        logic signed [EAST_W-1:0]  ee;
        logic signed [NORTH_W-1:0] sn;
        logic signed [NORTH_W-1:0] en;
        longint de, dn, x, y, z, xs, ys, top;
        longint unsigned ae, an, ang, r, q90, full;
        se = pair[28:0];
        sn = pair[56:29];
        ee = pair[85:57];
        en = pair[113:86];
        de = clip_diff(longint'(ee) - longint'(se));
        dn = clip_diff(longint'(en) - longint'(sn));
        ae = (de < 0) ? $unsigned(-de) : $unsigned(de);
        an = (dn < 0) ? $unsigned(-dn) : $unsigned(dn);
        q90  = 64'd90 << ANGLE_FRAC_BITS;
        full = 64'd360 << ANGLE_FRAC_BITS;
        if (an < thr || an == 0) begin
            kind = bftp_pkg::DIR_NORTH_ZERO;
            r = (de < 0) ? 3 * q90 : q90;
        end else if (ae < thr || ae == 0) begin
            kind = bftp_pkg::DIR_EAST_ZERO;
            r = (dn > 0) ? 64'd0 : 2 * q90;
        end else begin
            kind = bftp_pkg::DIR_GENERAL;
            // vectoring rotations drive y to zero, z collects the angle
            x = $signed(ae << (61 - COORD_BITS));
            y = $signed(an << (61 - COORD_BITS));
            z = 0;
            for (int i = 0; i < ATAN_STAGES && i < bftp_pkg::ATAN_TAB_LEN; i++) begin
                xs = x >>> i;
                ys = y >>> i;
                if (y >= 0) begin
                    x = x + ys;
                    y = y - xs;
                    z = z + longint'(bftp_pkg::ATAN_TAB[i]);
                end else begin
                    x = x - ys;
                    y = y + xs;
                    z = z - longint'(bftp_pkg::ATAN_TAB[i]);
                end
            end
            top = 64'sd90 <<< ACC_FRAC;
            if (z < 0) z = 0;
            if (z > top) z = top;
            ang = ($unsigned(z) + (64'd1 << (ACC_FRAC - ANGLE_FRAC_BITS - 1)))
                  >> (ACC_FRAC - ANGLE_FRAC_BITS);
            // quadrant placement
            if (dn > 0)
                r = (de > 0) ? q90 - ang : 3 * q90 + ang;
            else
                r = (de > 0) ? q90 + ang : 3 * q90 - ang;
            if (r >= full) r = r - full;
        end
        return r[BEARING_W-1:0];
    endfunction

    function automatic int rand_lon();
        return int'($urandom_range(0, 360000000)) - 180000000;
    endfunction

    function automatic int rand_lat();
        return int'($urandom_range(0, 180000000)) - 90000000;
    endfunction

    // random pair: mostly sensible tracks, some raw bit patterns and edge shapes
    function automatic pair_row_t gen_pair(input logic [THR_W-1:0] thr);
        pair_row_t row;
        int        pick;
        int        span;
        int        lons [5];
        int        lats [5];
        lons = '{-180000000, 180000000, 0, -1, 1};
        lats = '{-90000000, 90000000, 0, -1, 1};
        row = '0;
        pick = $urandom_range(0, 99);
        span = int'(thr) + 3;
        row.start_east  = EAST_W'(rand_lon());
        row.start_north = NORTH_W'(rand_lat());
        row.end_east    = EAST_W'(rand_lon());
        row.end_north   = NORTH_W'(rand_lat());
        if (pick < 35) begin
            // in-range coordinates as generated
        end else if (pick < 55) begin
            row.start_east  = EAST_W'($urandom());
            row.start_north = NORTH_W'($urandom());
            row.end_east    = EAST_W'($urandom());
            row.end_north   = NORTH_W'($urandom());
        end else if (pick < 80) begin
            // differences straddling the zero threshold
            row.end_north = NORTH_W'(row.start_north
                            + (int'($urandom_range(0, 2 * span)) - span));
            if ($urandom_range(0, 1))
                row.end_east = EAST_W'(row.start_east
                               + (int'($urandom_range(0, 2 * span)) - span));
            if ($urandom_range(0, 3) == 0) begin
                row.end_east  = EAST_W'(row.start_east
                                + (int'($urandom_range(0, 2 * span)) - span));
                row.end_north = NORTH_W'(rand_lat());
            end
        end else if (pick < 90) begin
            if ($urandom_range(0, 1))
                row.end_east = row.start_east;
            else
                row.end_north = row.start_north;
        end else begin
            row.start_east  = EAST_W'(lons[$urandom_range(0, 4)]);
            row.start_north = NORTH_W'(lats[$urandom_range(0, 4)]);
            row.end_east    = EAST_W'(lons[$urandom_range(0, 4)]);
            row.end_north   = NORTH_W'(lats[$urandom_range(0, 4)]);
        end
        return row;
    endfunction

    // offer one pair, with random idle cycles ahead of it, until taken
    task automatic send_pair(input pair_row_t row);
        row_answer_q = {row_answer_q, row};
        while ($urandom_range(0, 99) < src_idle_pct) begin
            s_tvalid <= 1'b0;
            @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {6'b0, row.end_north, row.end_east, row.start_north, row.start_east};
        do @(posedge aclk); while (!s_tready);
        @(negedge aclk);
    endtask

    // wait for the pipe to empty, then write the zero threshold
    task automatic write_threshold(input logic [THR_W-1:0] value);
        s_tvalid <= 1'b0;
        while (bearing_q.size() != 0) @(negedge aclk);
        cfg_we    <= 1'b1;
        cfg_wdata <= value;
        @(negedge aclk);
        cfg_we    <= 1'b0;
        @(negedge aclk);
    endtask

    task automatic run_random(input int count, input int idle, input int stall);
        src_idle_pct   = idle;
        sink_stall_pct = stall;
        repeat (count) send_pair(gen_pair(zero_thr));
    endtask

    // result side: random stalls, plus one long hold when asked
    always @(negedge aclk) begin
        if (hold_ask && !hold_taken) begin
            hold_taken = 1'b1;
            hold_left  = HOLD_CYCLES;
        end
        if (hold_left != 0) begin
            m_tready <= 1'b0;
            hold_left = hold_left - 1;
        end else begin
            m_tready <= ($urandom_range(0, 99) >= sink_stall_pct);
        end
    end

    // predict on each accepted pair, check each delivered bearing
    always @(posedge aclk) begin
        pair_row_t            row;
        bearing_exp_t         exp_b;
        bftp_pkg::dir_kind_t  kind;
        logic [BEARING_W-1:0] b;
        if (aresetn) begin
            if (cfg_we)
                zero_thr = cfg_wdata;
            if (s_tvalid && s_tready) begin
                row = row_answer_q.pop_front();
                b = predict_bearing(s_tdata, zero_thr, kind);
                if (row.known)
                    b = row.want;
                case (kind)
                    bftp_pkg::DIR_NORTH_ZERO: n_nzero++;
                    bftp_pkg::DIR_EAST_ZERO:  n_ezero++;
                    default:                  n_general++;
                endcase
                exp_b.pair = s_tdata;
                exp_b.word = {{(OUT_DATA_W - BEARING_W){1'b0}}, b};
                bearing_q = {bearing_q, exp_b};
                n_pairs++;
            end
            if (m_tvalid && m_tready) begin
                if (bearing_q.size() == 0) begin
                    mismatches++;
                    if (mismatches <= MAX_REPORTS)
                        $display("unexpected bearing beat %h", m_tdata);
                end else begin
                    exp_b = bearing_q.pop_front();
                    n_checked++;
                    if (m_tdata !== exp_b.word) begin
                        mismatches++;
                        if (mismatches <= MAX_REPORTS)
                            $display("bearing mismatch for pair %h: expected %h got %h",
                                     exp_b.pair, exp_b.word, m_tdata);
                    end
                end
            end
        end
    end

    // watchdog
    always @(posedge aclk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d bearings outstanding",
                     cycles, bearing_q.size());
            $display("CHECKS FAILED");
            $finish;
        end
    end

    initial begin
        pair_row_t row;
        repeat (4) @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // directed pairs at the reset threshold, no idling
        for (int k = 0; k < N_DIRECTED; k++) begin
            row = DIRECTED_ROWS[k];
            send_pair(row);
        end
        run_random(100, 0, 0);

        // threshold extremes and mid values across idle mixes
        write_threshold(20'd0);
        run_random(100, 84, 0);
        write_threshold(20'd1000);
        run_random(100, 0, 84);
        write_threshold(20'hFFFFF);
        run_random(100, 33, 33);

        // long output hold while the input keeps offering
        write_threshold(20'd1000000);
        src_idle_pct   = 0;
        sink_stall_pct = 0;
        hold_ask       = 1'b1;
        repeat (100) send_pair(gen_pair(zero_thr));

        write_threshold(THR_W'($urandom_range(1, 5000)));
        run_random(130, 33, 33);

        // drain, then give the pipe time to show any stray beat
        s_tvalid <= 1'b0;
        while (bearing_q.size() != 0) @(negedge aclk);
        repeat (PIPE_LAT + 8) @(negedge aclk);

        $display("%0d point pairs sent: %0d north-zero, %0d east-zero, %0d by arctangent",
                 n_pairs, n_nzero, n_ezero, n_general);
        $display("%0d bearings compared over six threshold settings, idle mixes and a long hold",
                 n_checked);
        if (mismatches == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("%0d mismatches", mismatches);
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule

### sim.f
hdl/bftp_pkg.sv
hdl/bearing_from_two_points_unit.sv
tb/testbench.sv
